[sv/mexp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, register map and reset values shared by the exponentiation core.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // Default modulus width and exponent width of the core.
    localparam int MODULUS_WIDTH  = 31;
    localparam int EXPONENT_WIDTH = 63;

    // Fixed widths of the base input and the result output.
    localparam int BASE_WIDTH   = 63;
    localparam int RESULT_WIDTH = 31;

    // Configuration port geometry.
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;

    // Register index of the modulus (byte address is four times the index).
    localparam logic REG_MODULUS = 1'b0;

    // Modulus after reset.
    localparam logic [30:0] MODULUS_RESET = 31'd1000000007;

    // Request to the shared modular multiplier.
    typedef struct packed {
        logic start;
        logic full;   // Walk every multiplier bit instead of the low modulus bits.
    } mm_req_t;

endpackage : mexp_pkg
`default_nettype wire

[sv/mexp_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation configuration registers
// APB-style register file holding the modulus.
// ----------------------------------------------------------------------------
module mexp_cfg #(
    parameter int MODULUS_WIDTH = mexp_pkg::MODULUS_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mexp_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [mexp_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic      [mexp_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                     pready,
    output logic      [MODULUS_WIDTH-1:0]            modulus
);

    localparam logic [MODULUS_WIDTH-1:0] MOD_RST = mexp_pkg::MODULUS_RESET[MODULUS_WIDTH-1:0];

    logic                     wr_en;
    logic                     sel_modulus;
    logic [MODULUS_WIDTH-1:0] modulus_reg;
    logic [MODULUS_WIDTH-1:0] modulus_next;

    // Address decode: word index sits above the two byte-offset bits.
    assign sel_modulus = (paddr[mexp_pkg::APB_ADDR_WIDTH-1:2] == mexp_pkg::REG_MODULUS);
    assign wr_en       = psel && penable && pwrite;
    assign pready      = 1'b1;

    // Write path.
    always_comb
    begin
        modulus_next = modulus_reg;
        if (wr_en && sel_modulus)
        begin
            modulus_next = pwdata[MODULUS_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RST;
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    // Read path.
    always_comb
    begin
        prdata = '0;
        if (sel_modulus)
        begin
            prdata = mexp_pkg::APB_DATA_WIDTH'(modulus_reg);
        end
    end

    assign modulus = modulus_reg;

endmodule : mexp_cfg
`default_nettype wire

[sv/mexp_modmul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation shared multiplier
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle,
// doubling and conditional add, each followed by one conditional subtract.
// ----------------------------------------------------------------------------
module mexp_modmul #(
    parameter int MODULUS_WIDTH = mexp_pkg::MODULUS_WIDTH,
    parameter int A_WIDTH       = mexp_pkg::BASE_WIDTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mexp_pkg::mm_req_t        req,
    input  wire logic [A_WIDTH-1:0]       op_a,     // multiplier, any value
    input  wire logic [MODULUS_WIDTH-1:0] op_b,     // multiplicand, below modulus
    input  wire logic [MODULUS_WIDTH-1:0] modulus,  // nonzero
    output logic                          done,
    output logic      [MODULUS_WIDTH-1:0] result
);

    localparam int CW = $clog2(A_WIDTH + 1);
    localparam int MW = MODULUS_WIDTH;

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [A_WIDTH-1:0] a_reg, a_next;
    logic [MW-1:0]  b_reg, b_next;
    logic [MW-1:0]  m_reg, m_next;
    logic [MW-1:0]  acc_reg, acc_next;

    logic [MW:0]    dbl;
    logic [MW-1:0]  dbl_red;
    logic [MW:0]    sum;
    logic [MW-1:0]  step_val;

    // One step: acc = (2*acc + bit*b) mod m, with both partial values below 2m.
    always_comb
    begin
        dbl      = {acc_reg, 1'b0};
        dbl_red  = (dbl >= {1'b0, m_reg}) ? MW'(dbl - {1'b0, m_reg}) : dbl[MW-1:0];
        sum      = {1'b0, dbl_red} + (a_reg[A_WIDTH-1] ? {1'b0, b_reg} : '0);
        step_val = (sum >= {1'b0, m_reg}) ? MW'(sum - {1'b0, m_reg}) : sum[MW-1:0];
    end

    // Sequencing of the bit walk.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            b_next    = op_b;
            m_next    = modulus;
            acc_next  = '0;
            if (req.full)
            begin
                a_next   = op_a;
                cnt_next = CW'(A_WIDTH);
            end
            else
            begin
                a_next   = {op_a[MW-1:0], {(A_WIDTH - MW){1'b0}}};
                cnt_next = CW'(MW);
            end
        end
        else if (busy_reg)
        begin
            acc_next = step_val;
            a_next   = {a_reg[A_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule : mexp_modmul
`default_nettype wire

[sv/modular_exponentiation_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Computes base to the power exponent modulo a programmable modulus.
// ----------------------------------------------------------------------------
// Each request carries a base and an exponent and yields one result,
// base^exponent mod modulus, by right-to-left square-and-multiply. All
// arithmetic runs on one bit-serial modular multiplier that handles one
// multiplier bit per cycle. The base is first reduced over all BASE_WIDTH
// (63) bits; then every exponent bit below the highest set bit costs one
// squaring over MODULUS_WIDTH bits, and every set bit costs one
// multiplication over MODULUS_WIDTH bits. in_stall is high for the whole
// computation. The finished result sits in an output register, so a new
// request is taken while the previous result still waits. A modulus of
// zero acts as a modulus of one, and an exponent of zero always returns one.
// The user must write the modulus only while the core is idle; the core
// itself does not enforce this.
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
    parameter int MODULUS_WIDTH  = mexp_pkg::MODULUS_WIDTH,
    parameter int EXPONENT_WIDTH = mexp_pkg::EXPONENT_WIDTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [mexp_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  wire logic [mexp_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic      [mexp_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                       pready,
    // Request channel
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [mexp_pkg::BASE_WIDTH-1:0]       base,
    input  wire logic [EXPONENT_WIDTH-1:0]             exponent,
    // Result channel
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic      [mexp_pkg::RESULT_WIDTH-1:0]     power_result
);

    localparam int MW = MODULUS_WIDTH;
    localparam int AW = mexp_pkg::BASE_WIDTH;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REDUCE = 6'b000010,
        ST_STEP   = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_SQR    = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [EXPONENT_WIDTH-1:0] e_reg, e_next;
    logic [MW-1:0]       acc_reg, acc_next;
    logic [MW-1:0]       b_reg, b_next;
    logic                out_valid_reg, out_valid_next;
    logic [MW-1:0]       out_data_reg, out_data_next;

    logic [MW-1:0]       modulus;
    logic [MW-1:0]       m_eff;
    logic                in_take;
    logic                e_upper_zero;

    mexp_pkg::mm_req_t   mm_req;
    logic [AW-1:0]       mm_a;
    logic [MW-1:0]       mm_b;
    logic                mm_done;
    logic [MW-1:0]       mm_result;

    // Register file.
    mexp_cfg #(
        .MODULUS_WIDTH (MW)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .modulus (modulus)
    );

    // Shared modular multiplier.
    mexp_modmul #(
        .MODULUS_WIDTH (MW),
        .A_WIDTH       (AW)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mm_req),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .modulus (m_eff),
        .done    (mm_done),
        .result  (mm_result)
    );

    // A zero modulus behaves as a modulus of one.
    assign m_eff        = (modulus == '0) ? MW'(1) : modulus;
    assign in_stall     = (state_reg != ST_IDLE);
    assign in_take      = in_valid && !in_stall;
    assign e_upper_zero = ((e_reg >> 1) == '0);

    // Sequencer for reduction, multiply and square steps.
    always_comb
    begin
        state_next     = state_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        b_next         = b_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        mm_req         = '0;
        mm_a           = AW'(b_reg);
        mm_b           = b_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Reduce the base as base * 1 mod m.
                mm_a = base;
                mm_b = (m_eff == MW'(1)) ? '0 : MW'(1);
                if (in_take)
                begin
                    e_next      = exponent;
                    acc_next    = MW'(1);
                    mm_req      = '{start: 1'b1, full: 1'b1};
                    state_next  = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (mm_done)
                begin
                    b_next     = mm_result;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (e_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (e_reg[0])
                begin
                    mm_a       = AW'(acc_reg);
                    mm_req     = '{start: 1'b1, full: 1'b0};
                    state_next = ST_MUL;
                end
                else
                begin
                    mm_req     = '{start: 1'b1, full: 1'b0};
                    state_next = ST_SQR;
                end
            end
            ST_MUL:
            begin
                if (mm_done)
                begin
                    acc_next = mm_result;
                    if (e_upper_zero)
                    begin
                        // Last set bit: the square would never be used.
                        e_next     = '0;
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        mm_req     = '{start: 1'b1, full: 1'b0};
                        state_next = ST_SQR;
                    end
                end
            end
            ST_SQR:
            begin
                if (mm_done)
                begin
                    b_next     = mm_result;
                    e_next     = e_reg >> 1;
                    state_next = ST_STEP;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg        <= e_next;
        acc_reg      <= acc_next;
        b_reg        <= b_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid    = out_valid_reg;
    assign power_result = mexp_pkg::RESULT_WIDTH'(out_data_reg);

endmodule : modular_exponentiation_core
`default_nettype wire

[sv/mexp_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation port checker
// Concurrent checks on the request and result channels of the core.
// ----------------------------------------------------------------------------
module mexp_checker (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    input  wire logic                                  in_stall,
    input  wire logic                                  out_valid,
    input  wire logic                                  out_stall,
    input  wire logic [mexp_pkg::RESULT_WIDTH-1:0]     power_result
);

    // A taken request keeps the core busy on the following cycle.
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("core accepted a request and was not busy after it");

    // A new result only appears at the end of a busy period.
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a computation");

    // With no result pending, none appears in the cycle after an accepted request.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_valid) |=> !out_valid)
        else $error("result appeared right after a request");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(power_result)))
        else $error("stalled result dropped or changed");

endmodule : mexp_checker

bind modular_exponentiation_core mexp_checker u_mexp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .power_result (power_result)
);
`default_nettype wire
